@@ rtl/core/frustum_volume_classifier_top_defines.svh @@
// ----------------------------------------------------------------------------
// Frustum volume classifier assertion macros
// Concurrent assertion wrappers used by the top level; define NO_ASSERTIONS
// to compile them out.
// ----------------------------------------------------------------------------
`ifndef FRUSTUM_VOLUME_CLASSIFIER_TOP_DEFINES_SVH
`define FRUSTUM_VOLUME_CLASSIFIER_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication, sampled on clock, off during reset
`define FVC_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("fvc assertion failed: same-cycle check");
// next-cycle implication, sampled on clock, off during reset
`define FVC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("fvc assertion failed: next-cycle check");
`else
`define FVC_ASSERT_NOW(label, ante, cons)
`define FVC_ASSERT_NEXT(label, ante, cons)
`endif

`endif

@@ rtl/core/fvc_pkg.sv @@
// ----------------------------------------------------------------------------
// fvc_pkg
// Shared types, codes and arithmetic helpers of the frustum volume classifier.
// ----------------------------------------------------------------------------
package fvc_pkg;

   localparam int PLANE_COUNT_DEFAULT = 6;
   localparam int COORD_BITS_DEFAULT  = 16;
   localparam int NUM_REGS            = 6;
   localparam int CSR_INDEX_BITS      = 3;
   localparam int CSR_DATA_BITS       = 64;

   localparam int FIELD_BITS    = 16;
   localparam int COORD_X_BITS  = 17;   // field value after width handling
   localparam int RADIUS_BITS   = 15;
   localparam int SCALE_BITS    = 16;
   localparam int PROD_BITS     = FIELD_BITS + COORD_X_BITS;        // 33
   localparam int DOT_BITS      = PROD_BITS + 2;                    // 35
   localparam int RDIFF_BITS    = 18;
   localparam int DIST22_BITS   = DOT_BITS + 1;                     // 36
   localparam int SCALED_BITS   = DOT_BITS + SCALE_BITS + 1;        // 52
   localparam int DIST30_BITS   = SCALED_BITS + 1;                  // 53
   localparam int LANE_STAGES   = 4;

   localparam logic [1:0] REQ_POINT    = 2'd0;
   localparam logic [1:0] REQ_SPHERE   = 2'd1;
   localparam logic [1:0] REQ_TRIANGLE = 2'd2;
   localparam logic [1:0] REQ_VOLUME   = 2'd3;

   localparam logic [1:0] VERDICT_CONTAINS  = 2'd0;
   localparam logic [1:0] VERDICT_INTERSECT = 2'd1;
   localparam logic [1:0] VERDICT_OUTSIDE   = 2'd2;

   typedef logic signed [COORD_X_BITS-1:0] fvc_coord_type;

   typedef struct packed {
      fvc_coord_type z;
      fvc_coord_type y;
      fvc_coord_type x;
   } fvc_vertex_type;

   // matches the register layout: offset in the top 16 bits, normal x lowest
   typedef struct packed {
      logic signed [FIELD_BITS-1:0] off;
      logic signed [FIELD_BITS-1:0] nz;
      logic signed [FIELD_BITS-1:0] ny;
      logic signed [FIELD_BITS-1:0] nx;
   } fvc_plane_type;

   typedef struct packed {
      logic [LANE_STAGES-1:0] load;
   } fvc_stage_ctl_type;

   typedef struct packed {
      logic outside;
      logic partial;
   } fvc_lane_res_type;

   // exact product of a Q1.14 normal component and a coordinate
   function automatic logic signed [PROD_BITS-1:0] mul_nv(
      input logic signed [FIELD_BITS-1:0]   n,
      input logic signed [COORD_X_BITS-1:0] v
   );
      logic signed [PROD_BITS-1:0] n_ext;
      logic signed [PROD_BITS-1:0] v_ext;
      n_ext = PROD_BITS'(n);
      v_ext = PROD_BITS'(v);
      return n_ext * v_ext;
   endfunction

endpackage

@@ rtl/core/frustum_volume_classifier_top.sv @@
// ----------------------------------------------------------------------------
// frustum_volume_classifier_top
// Point, sphere, triangle and triangle-volume test against the frustum planes,
// one lane per plane, findings merged into contains / intersects / outside.
// ----------------------------------------------------------------------------
//  channel   ports                       direction   handshake
//  request   req_*  (type, vertices...)  in          req_valid / req_ready
//  response  rsp_verdict                 out         rsp_valid / rsp_ready
//  csr       csr_wr_en/index/wdata       in          write on csr_wr_en
//
//  One beat per cycle while responses are taken; a request passes four lane
//  stages (products, dot sums, distances and scaled products, plane finding)
//  and then the output register of the merge.
//  Each stage holds only while its successor is full and held, so a stalled
//  response fills the pipe before req_ready drops.
//  Reset clears the plane registers to zero and empties the pipe.
// ----------------------------------------------------------------------------
`include "frustum_volume_classifier_top_defines.svh"

module frustum_volume_classifier_top #(
   parameter int PLANE_COUNT = fvc_pkg::PLANE_COUNT_DEFAULT,
   parameter int COORD_BITS  = fvc_pkg::COORD_BITS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [1:0]                            req_type,
   input  logic signed [fvc_pkg::FIELD_BITS-1:0] req_a_x,
   input  logic signed [fvc_pkg::FIELD_BITS-1:0] req_a_y,
   input  logic signed [fvc_pkg::FIELD_BITS-1:0] req_a_z,
   input  logic signed [fvc_pkg::FIELD_BITS-1:0] req_b_x,
   input  logic signed [fvc_pkg::FIELD_BITS-1:0] req_b_y,
   input  logic signed [fvc_pkg::FIELD_BITS-1:0] req_b_z,
   input  logic signed [fvc_pkg::FIELD_BITS-1:0] req_c_x,
   input  logic signed [fvc_pkg::FIELD_BITS-1:0] req_c_y,
   input  logic signed [fvc_pkg::FIELD_BITS-1:0] req_c_z,
   input  logic [fvc_pkg::RADIUS_BITS-1:0]       req_sphere_radius,
   input  logic [fvc_pkg::SCALE_BITS-1:0]        req_extrude_scale,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [1:0]                            rsp_verdict,
   input  logic                                  csr_wr_en,
   input  logic [fvc_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [fvc_pkg::CSR_DATA_BITS-1:0]     csr_wdata
);

   localparam int REG_SLOTS   = (PLANE_COUNT < fvc_pkg::NUM_REGS) ? PLANE_COUNT
                                                                  : fvc_pkg::NUM_REGS;
   localparam int STAGES      = fvc_pkg::LANE_STAGES;
   localparam bit SIGN_EXT    = (COORD_BITS <= fvc_pkg::FIELD_BITS);
   localparam int FIELD_SHIFT = SIGN_EXT ? (fvc_pkg::FIELD_BITS - COORD_BITS) : 0;

   // narrow widths sign-extend the low bits; wider ones see the field as positive
   function automatic fvc_pkg::fvc_coord_type coord_ext(
      input logic [fvc_pkg::FIELD_BITS-1:0] f
   );
      logic [fvc_pkg::FIELD_BITS-1:0] sh;
      sh = f << FIELD_SHIFT;
      if (SIGN_EXT) begin
         return $signed({sh[fvc_pkg::FIELD_BITS-1], sh}) >>> FIELD_SHIFT;
      end else begin
         return $signed({1'b0, f});
      end
   endfunction

   logic [fvc_pkg::CSR_DATA_BITS-1:0] plane_ff [REG_SLOTS];
   logic [STAGES-1:0]                 stg_valid_ff;
   logic [STAGES-1:0]                 stg_valid_in;
   logic [STAGES:0]                   stg_load;
   logic                              merge_ready;
   fvc_pkg::fvc_stage_ctl_type        ctl;
   fvc_pkg::fvc_vertex_type           vtx [3];
   fvc_pkg::fvc_lane_res_type         lane_res [PLANE_COUNT];

   // plane registers; indexes past the stored slots are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < REG_SLOTS; i++) begin
            plane_ff[i] <= '0;
         end
      end else begin
         for (int i = 0; i < REG_SLOTS; i++) begin
            if (csr_wr_en && (csr_index == fvc_pkg::CSR_INDEX_BITS'(i))) begin
               plane_ff[i] <= csr_wdata;
            end
         end
      end
   end

   always_comb begin
      vtx[0].x = coord_ext(req_a_x);
      vtx[0].y = coord_ext(req_a_y);
      vtx[0].z = coord_ext(req_a_z);
      vtx[1].x = coord_ext(req_b_x);
      vtx[1].y = coord_ext(req_b_y);
      vtx[1].z = coord_ext(req_b_z);
      vtx[2].x = coord_ext(req_c_x);
      vtx[2].y = coord_ext(req_c_y);
      vtx[2].z = coord_ext(req_c_z);
   end

   // a stage advances when empty or when the next one advances
   always_comb begin
      stg_load[STAGES] = merge_ready;
      for (int s = STAGES - 1; s >= 0; s--) begin
         stg_load[s] = ~stg_valid_ff[s] | stg_load[s+1];
      end
      for (int s = 0; s < STAGES; s++) begin
         if (stg_load[s]) begin
            stg_valid_in[s] = (s == 0) ? req_valid : stg_valid_ff[(s == 0) ? 0 : s - 1];
         end else begin
            stg_valid_in[s] = stg_valid_ff[s];
         end
      end
      ctl.load = stg_load[STAGES-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff <= '0;
      end else begin
         stg_valid_ff <= stg_valid_in;
      end
   end

   assign req_ready = stg_load[0];

   for (genvar i = 0; i < PLANE_COUNT; i++) begin : g_lane
      fvc_pkg::fvc_plane_type plane;
      if (i < REG_SLOTS) begin : g_stored
         assign plane = fvc_pkg::fvc_plane_type'(plane_ff[i]);
      end else begin : g_zero
         assign plane = '0;
      end
      fvc_lane u_lane (
         .clock  (clock),
         .ctl    (ctl),
         .plane  (plane),
         .vtx    (vtx),
         .kind   (req_type),
         .radius (req_sphere_radius),
         .scale  (req_extrude_scale),
         .res    (lane_res[i])
      );
   end

   fvc_merge #(
      .LANE_COUNT (PLANE_COUNT)
   ) u_merge (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (stg_valid_ff[STAGES-1]),
      .in_ready    (merge_ready),
      .lane_res    (lane_res),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_verdict (rsp_verdict)
   );

   `FVC_ASSERT_NEXT(a_accept_fills_first_stage, req_valid && req_ready, stg_valid_ff[0])
   `FVC_ASSERT_NOW(a_full_stall_blocks_input, rsp_valid && !rsp_ready && (&stg_valid_ff), !req_ready)
   `FVC_ASSERT_NEXT(a_drain_empties_output, rsp_valid && rsp_ready && !stg_valid_ff[STAGES-1], !rsp_valid)

endmodule

@@ rtl/core/fvc_lane.sv @@
// ----------------------------------------------------------------------------
// fvc_lane
// One plane test: four registered stages from products to a per-plane finding.
// ----------------------------------------------------------------------------
module fvc_lane (
   input  logic                                clock,
   input  fvc_pkg::fvc_stage_ctl_type          ctl,
   input  fvc_pkg::fvc_plane_type              plane,
   input  fvc_pkg::fvc_vertex_type             vtx [3],
   input  logic [1:0]                          kind,
   input  logic [fvc_pkg::RADIUS_BITS-1:0]     radius,
   input  logic [fvc_pkg::SCALE_BITS-1:0]      scale,
   output fvc_pkg::fvc_lane_res_type           res
);

   // stage 0: nine products
   logic signed [fvc_pkg::PROD_BITS-1:0]   s0_prod_in [3][3];
   logic signed [fvc_pkg::PROD_BITS-1:0]   s0_prod_ff [3][3];
   logic signed [fvc_pkg::RDIFF_BITS-1:0]  s0_rdiff_in;
   logic signed [fvc_pkg::RDIFF_BITS-1:0]  s0_rdiff_ff;
   logic signed [fvc_pkg::FIELD_BITS-1:0]  s0_off_ff;
   logic [1:0]                             s0_kind_ff;
   logic [fvc_pkg::SCALE_BITS-1:0]         s0_scale_ff;

   // stage 1: dot products
   logic signed [fvc_pkg::DOT_BITS-1:0]    s1_dot_in [3];
   logic signed [fvc_pkg::DOT_BITS-1:0]    s1_dot_ff [3];
   logic signed [fvc_pkg::RDIFF_BITS-1:0]  s1_rdiff_ff;
   logic signed [fvc_pkg::FIELD_BITS-1:0]  s1_off_ff;
   logic [1:0]                             s1_kind_ff;
   logic [fvc_pkg::SCALE_BITS-1:0]         s1_scale_ff;

   // stage 2: signs of the plain distances, scaled dot products
   logic [2:0]                             s2_neg_in;
   logic [2:0]                             s2_neg_ff;
   logic                                   s2_sph_out_in;
   logic                                   s2_sph_out_ff;
   logic signed [fvc_pkg::SCALED_BITS-1:0] s2_scaled_in [3];
   logic signed [fvc_pkg::SCALED_BITS-1:0] s2_scaled_ff [3];
   logic signed [fvc_pkg::FIELD_BITS-1:0]  s2_off_ff;
   logic [1:0]                             s2_kind_ff;

   // stage 3: finding of this plane
   logic [2:0]                             s3_neg30;
   fvc_pkg::fvc_lane_res_type              s3_res_in;
   fvc_pkg::fvc_lane_res_type              s3_res_ff;

   logic signed [fvc_pkg::DIST22_BITS-1:0] off22;
   logic signed [fvc_pkg::DIST22_BITS-1:0] dist22 [3];
   logic signed [fvc_pkg::DIST22_BITS-1:0] sph_dist;
   logic signed [fvc_pkg::SCALED_BITS-1:0] scale_s;
   logic signed [fvc_pkg::DIST30_BITS-1:0] off30;
   logic signed [fvc_pkg::DIST30_BITS-1:0] dist30 [3];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         s0_prod_in[k][0] = fvc_pkg::mul_nv(plane.nx, vtx[k].x);
         s0_prod_in[k][1] = fvc_pkg::mul_nv(plane.ny, vtx[k].y);
         s0_prod_in[k][2] = fvc_pkg::mul_nv(plane.nz, vtx[k].z);
      end
      // radius minus offset, so the sphere test is a single add later
      s0_rdiff_in = $signed({3'b000, radius}) - fvc_pkg::RDIFF_BITS'(plane.off);
   end

   always_ff @(posedge clock) begin
      if (ctl.load[0]) begin
         s0_prod_ff  <= s0_prod_in;
         s0_rdiff_ff <= s0_rdiff_in;
         s0_off_ff   <= plane.off;
         s0_kind_ff  <= kind;
         s0_scale_ff <= scale;
      end
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         s1_dot_in[k] = fvc_pkg::DOT_BITS'(s0_prod_ff[k][0])
                      + fvc_pkg::DOT_BITS'(s0_prod_ff[k][1])
                      + fvc_pkg::DOT_BITS'(s0_prod_ff[k][2]);
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load[1]) begin
         s1_dot_ff   <= s1_dot_in;
         s1_rdiff_ff <= s0_rdiff_ff;
         s1_off_ff   <= s0_off_ff;
         s1_kind_ff  <= s0_kind_ff;
         s1_scale_ff <= s0_scale_ff;
      end
   end

   always_comb begin
      off22    = fvc_pkg::DIST22_BITS'($signed({s1_off_ff, 14'b0}));
      scale_s  = fvc_pkg::SCALED_BITS'($signed({1'b0, s1_scale_ff}));
      for (int k = 0; k < 3; k++) begin
         dist22[k]       = fvc_pkg::DIST22_BITS'(s1_dot_ff[k]) - off22;
         s2_neg_in[k]    = dist22[k][fvc_pkg::DIST22_BITS-1];
         s2_scaled_in[k] = fvc_pkg::SCALED_BITS'(s1_dot_ff[k]) * scale_s;
      end
      sph_dist      = fvc_pkg::DIST22_BITS'(s1_dot_ff[0])
                    + fvc_pkg::DIST22_BITS'($signed({s1_rdiff_ff, 14'b0}));
      s2_sph_out_in = sph_dist[fvc_pkg::DIST22_BITS-1];
   end

   always_ff @(posedge clock) begin
      if (ctl.load[2]) begin
         s2_neg_ff     <= s2_neg_in;
         s2_sph_out_ff <= s2_sph_out_in;
         s2_scaled_ff  <= s2_scaled_in;
         s2_off_ff     <= s1_off_ff;
         s2_kind_ff    <= s1_kind_ff;
      end
   end

   always_comb begin
      off30 = fvc_pkg::DIST30_BITS'($signed({s2_off_ff, 22'b0}));
      for (int k = 0; k < 3; k++) begin
         dist30[k]   = fvc_pkg::DIST30_BITS'(s2_scaled_ff[k]) - off30;
         s3_neg30[k] = dist30[k][fvc_pkg::DIST30_BITS-1];
      end
      s3_res_in = '0;
      case (s2_kind_ff)
         fvc_pkg::REQ_POINT: begin
            s3_res_in.outside = s2_neg_ff[0];
         end
         fvc_pkg::REQ_SPHERE: begin
            s3_res_in.outside = s2_sph_out_ff;
            s3_res_in.partial = s2_neg_ff[0];
         end
         fvc_pkg::REQ_TRIANGLE: begin
            s3_res_in.outside = &s2_neg_ff;
            s3_res_in.partial = (|s2_neg_ff) & ~(&s2_neg_ff);
         end
         fvc_pkg::REQ_VOLUME: begin
            // fully behind: the scaled copy decides between outside and partial
            s3_res_in.outside = (&s2_neg_ff) & (&s3_neg30);
            s3_res_in.partial = (|s2_neg_ff) & ~((&s2_neg_ff) & (&s3_neg30));
         end
         default: begin
            s3_res_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (ctl.load[3]) begin
         s3_res_ff <= s3_res_in;
      end
   end

   assign res = s3_res_ff;

endmodule

@@ rtl/core/fvc_merge.sv @@
// ----------------------------------------------------------------------------
// fvc_merge
// Combines the per-plane findings into one verdict and holds it for the
// result channel.
// ----------------------------------------------------------------------------
module fvc_merge #(
   parameter int LANE_COUNT = fvc_pkg::PLANE_COUNT_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  fvc_pkg::fvc_lane_res_type     lane_res [LANE_COUNT],
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [1:0]                    rsp_verdict
);

   logic       any_outside;
   logic       any_partial;
   logic [1:0] verdict_in;
   logic [1:0] verdict_ff;
   logic       valid_in;
   logic       valid_ff;

   always_comb begin
      any_outside = 1'b0;
      any_partial = 1'b0;
      for (int i = 0; i < LANE_COUNT; i++) begin
         any_outside = any_outside | lane_res[i].outside;
         any_partial = any_partial | lane_res[i].partial;
      end
      // any plane that rejects wins over partial overlap elsewhere
      if (any_outside) begin
         verdict_in = fvc_pkg::VERDICT_OUTSIDE;
      end else if (any_partial) begin
         verdict_in = fvc_pkg::VERDICT_INTERSECT;
      end else begin
         verdict_in = fvc_pkg::VERDICT_CONTAINS;
      end
   end

   assign in_ready = ~valid_ff | rsp_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         verdict_ff <= verdict_in;
      end
   end

   assign rsp_valid   = valid_ff;
   assign rsp_verdict = verdict_ff;

endmodule
